@@ design/bss_pkg.sv @@
// Shared constants, codes and types of the bitmap set sorter.
package bss_pkg;

  localparam int VALUE_BITS = 16;
  localparam int WORD_BITS  = 32;
  localparam int BIT_BITS   = $clog2(WORD_BITS);
  localparam int NUM_WORDS  = ((1 << VALUE_BITS) + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_BITS  = $clog2(NUM_WORDS);
  localparam int CUR_BITS   = VALUE_BITS + 1;
  localparam int FUNC_BITS  = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_NEXT   = 2'd1,
    FUNC_REWIND = 2'd2
  } bss_func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_WR,
    ST_NXT_CHK
  } bss_state_t;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0] wdata;
  } bss_mem_req_t;

endpackage

@@ design/bss_ram.sv @@
// Single-port synchronous RAM with a registered read port.
module bss_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/bss_lowbit.sv @@
// Lowest set bit search over one bitmap word.
module bss_lowbit
  import bss_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  output logic                 any,
  output logic [BIT_BITS-1:0]  pos
);

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        pos = BIT_BITS'(i);
      end
    end
  end

  assign any = |word;

endmodule

@@ design/bss_ctrl.sv @@
// Sequencer that clears, updates and scans the presence bitmap.
module bss_ctrl
  import bss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [FUNC_BITS-1:0]  func,
  input  logic [VALUE_BITS-1:0] value_in,
  output logic                  busy,
  output bss_mem_req_t          mem_req,
  input  logic [WORD_BITS-1:0]  mem_rdata,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_value
);

  bss_state_t            state_r, state_nxt;
  logic [ADDR_BITS-1:0]  clr_idx_r, clr_idx_nxt;
  logic [CUR_BITS-1:0]   cursor_r, cursor_nxt;
  logic [ADDR_BITS-1:0]  scan_idx_r, scan_idx_nxt;
  logic                  first_r, first_nxt;
  logic [ADDR_BITS-1:0]  ins_addr_r, ins_addr_nxt;
  logic [BIT_BITS-1:0]   ins_bit_r, ins_bit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;

  logic                  accept;
  logic [WORD_BITS-1:0]  scan_mask;
  logic [WORD_BITS-1:0]  scan_word;
  logic                  hit_any;
  logic [BIT_BITS-1:0]   hit_pos;
  logic [VALUE_BITS-1:0] hit_value;

  assign accept = start && (state_r == ST_IDLE);

  assign scan_mask = first_r ? ({WORD_BITS{1'b1}} << cursor_r[BIT_BITS-1:0])
                             : {WORD_BITS{1'b1}};
  assign scan_word = mem_rdata & scan_mask;
  assign hit_value = {scan_idx_r, hit_pos};

  bss_lowbit u_lowbit (
    .word (scan_word),
    .any  (hit_any),
    .pos  (hit_pos)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == {ADDR_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (bss_func_t'(func))
            FUNC_INSERT: state_nxt = ST_INS_WR;
            FUNC_NEXT: begin
              if (!cursor_r[VALUE_BITS]) begin
                state_nxt = ST_NXT_CHK;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS_WR: state_nxt = ST_IDLE;
      ST_NXT_CHK: begin
        if (hit_any || (scan_idx_r == {ADDR_BITS{1'b1}})) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req       = '0;
    clr_idx_nxt   = clr_idx_r;
    cursor_nxt    = cursor_r;
    scan_idx_nxt  = scan_idx_r;
    first_nxt     = first_r;
    ins_addr_nxt  = ins_addr_r;
    ins_bit_nxt   = ins_bit_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we  = 1'b1;
        mem_req.addr = clr_idx_r;
        clr_idx_nxt = clr_idx_r + ADDR_BITS'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          case (bss_func_t'(func))
            FUNC_INSERT: begin
              mem_req.re   = 1'b1;
              mem_req.addr = value_in[VALUE_BITS-1:BIT_BITS];
              ins_addr_nxt = value_in[VALUE_BITS-1:BIT_BITS];
              ins_bit_nxt  = value_in[BIT_BITS-1:0];
            end
            FUNC_NEXT: begin
              if (cursor_r[VALUE_BITS]) begin
                out_valid_nxt = 1'b1;
                out_found_nxt = 1'b0;
                out_value_nxt = '0;
              end else begin
                mem_req.re   = 1'b1;
                mem_req.addr = cursor_r[VALUE_BITS-1:BIT_BITS];
                scan_idx_nxt = cursor_r[VALUE_BITS-1:BIT_BITS];
                first_nxt    = 1'b1;
              end
            end
            FUNC_REWIND: cursor_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_INS_WR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ins_addr_r;
        mem_req.wdata = mem_rdata | (WORD_BITS'(1) << ins_bit_r);
      end
      ST_NXT_CHK: begin
        first_nxt = 1'b0;
        if (hit_any) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_value_nxt = hit_value;
          cursor_nxt    = {1'b0, hit_value} + CUR_BITS'(1);
        end else if (scan_idx_r == {ADDR_BITS{1'b1}}) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_value_nxt = '0;
          cursor_nxt    = CUR_BITS'(1) << VALUE_BITS;
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = scan_idx_r + ADDR_BITS'(1);
          scan_idx_nxt = scan_idx_r + ADDR_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    first_r     <= first_nxt;
    ins_addr_r  <= ins_addr_nxt;
    ins_bit_r   <= ins_bit_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_value = out_value_r;

`ifndef NO_ASSERTIONS
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("Bitmap memory read and written in the same cycle.");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r[VALUE_BITS] |-> (cursor_r[VALUE_BITS-1:0] == '0))
    else $error("Scan cursor beyond the end of the value range.");

  a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_NXT_CHK || $past(state_r) == ST_IDLE))
    else $error("Result beat issued from an unexpected state.");

  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("Result beat during the clearing pass.");

  a_found_below_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (cursor_r == {1'b0, out_value_r} + CUR_BITS'(1)))
    else $error("Cursor does not follow the returned value.");
`endif

endmodule

@@ design/bitmap_set_sorter_top.sv @@
// Top level of the bitmap set sorter: sequencer plus bitmap memory.
//
// An item is taken at a rising edge with start high and busy low. in_func
// selects insert, next or rewind; in_value_in is the value for an insert.
// Insert sets one presence bit by a read and a write of one memory word.
// Rewind gives no beat. Next scans the bitmap one memory word per cycle
// from the cursor, examining 1 to 2048 words. Its beat is shown with
// out_valid high for one cycle; busy falls in that same cycle, so the next
// item may be taken while the beat is shown. A next with the scan already
// exhausted shows its not-found beat in the cycle right after the accepting
// edge. The single-port memory sets the rate: one word access per cycle.
// After reset a clearing pass writes zero to all 2048 words, one per cycle;
// busy stays high during the pass. The receiver cannot stall, so every beat
// is taken in the cycle it is shown.
module bitmap_set_sorter_top
  import bss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_BITS-1:0]  in_func,
  input  logic [VALUE_BITS-1:0] in_value_in,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_value_out
);

  bss_mem_req_t         mem_req;
  logic [WORD_BITS-1:0] mem_rdata;

  bss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_func),
    .value_in  (in_value_in),
    .busy      (busy),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_valid (out_valid),
    .out_found (out_found),
    .out_value (out_value_out)
  );

  bss_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule

@@ bench/bitmap_set_sorter_checker.sv @@
// Checker for the bitmap set sorter: tracks the bitmap and cursor, predicts next beats.
module bitmap_set_sorter_checker
  import bss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [FUNC_BITS-1:0]  in_func,
  input  logic [VALUE_BITS-1:0] in_value_in,
  input  logic                  out_valid,
  input  logic                  out_found,
  input  logic [VALUE_BITS-1:0] out_value_out,
  output int                    pending,
  output int                    fail_count
);

  localparam int VALUE_COUNT = 1 << VALUE_BITS;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] value;
  } scan_beat_t;

  logic [WORD_BITS-1:0] bitmap_words [NUM_WORDS];
  logic [CUR_BITS-1:0]  cursor;
  scan_beat_t           awaited_beats [$];
  int                   mismatches;

  // Finds the smallest present value at or above the cursor and moves the cursor past it, or to the end if none.
  task automatic scan_forward(output scan_beat_t beat);
    int pos;
    pos = int'(cursor);
    beat = '0;
    while (pos < VALUE_COUNT && !beat.found) begin
      if (pos % WORD_BITS == 0 && bitmap_words[pos / WORD_BITS] == '0) begin
        pos += WORD_BITS;
      end else if (bitmap_words[pos / WORD_BITS][pos % WORD_BITS]) begin
        beat.found = 1'b1;
        beat.value = pos[VALUE_BITS-1:0];
      end else begin
        pos++;
      end
    end
    cursor = beat.found ? CUR_BITS'(pos + 1) : CUR_BITS'(VALUE_COUNT);
  endtask

  always @(posedge clk) begin
    scan_beat_t want;
    if (!rst_n) begin
      foreach (bitmap_words[i]) bitmap_words[i] = '0;
      cursor = '0;
      awaited_beats.delete();
      mismatches = 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (awaited_beats.size() == 0) begin
          $error("unexpected beat: out_found %0d, out_value_out %0d", out_found,
                 out_value_out);
          mismatches++;
        end else begin
          want = awaited_beats.pop_front();
          if (out_found !== want.found) begin
            $error("out_found: expected %0d, actual %0d", want.found, out_found);
            mismatches++;
          end
          if (out_value_out !== want.value) begin
            $error("out_value_out: expected %0d, actual %0d", want.value, out_value_out);
            mismatches++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        case (in_func)
          FUNC_INSERT: begin
            bitmap_words[in_value_in[VALUE_BITS-1:BIT_BITS]][in_value_in[BIT_BITS-1:0]] = 1'b1;
          end
          FUNC_NEXT: begin
            scan_forward(want);
            awaited_beats.push_back(want);
          end
          FUNC_REWIND: begin
            cursor = '0;
          end
          default: ;
        endcase
      end
    end
    pending    <= awaited_beats.size();
    fail_count <= mismatches;
  end

endmodule

@@ bench/tb_bitmap_set_sorter_top.sv @@
// Testbench top of the bitmap set sorter: clock, reset, stimulus and verdict.
module tb_bitmap_set_sorter_top;
  import bss_pkg::*;

  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 1450;
  localparam int SETTLE_CYCLES = NUM_WORDS + 64;
  localparam int CYCLE_LIMIT   = 15_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [FUNC_BITS-1:0]  in_func;
  logic [VALUE_BITS-1:0] in_value_in;
  logic                  out_valid;
  logic                  out_found;
  logic [VALUE_BITS-1:0] out_value_out;
  int                    pending;
  int                    fail_count;
  int                    items_sent = 0;
  int                    cycle_count = 0;
  bit                    quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_set_sorter_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_value_out(out_value_out)
  );

  bitmap_set_sorter_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_value_out(out_value_out),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  task automatic send_item(input logic [FUNC_BITS-1:0] f, input logic [VALUE_BITS-1:0] v);
    if (!quiet && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start       <= 1'b1;
    in_func     <= f;
    in_value_in <= v;
    do @(posedge clk); while (busy !== 1'b0);
    if (f != FUNC_UNUSED) items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int                    base;
    int                    span;
    int                    n;
    int                    m;
    int                    k;
    int                    target;
    logic [VALUE_BITS-1:0] v;
    start       <= 1'b0;
    in_func     <= FUNC_INSERT;
    in_value_in <= '0;
    rst_n       <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_item(FUNC_NEXT, 16'h0000);
    send_item(FUNC_NEXT, 16'hFFFF);
    send_item(FUNC_REWIND, 16'h1234);
    send_item(FUNC_INSERT, 16'h0000);
    send_item(FUNC_INSERT, 16'hFFFF);
    send_item(FUNC_INSERT, 16'hFFFF);
    send_item(FUNC_INSERT, 16'd31);
    send_item(FUNC_INSERT, 16'd32);
    send_item(FUNC_UNUSED, 16'd5);
    send_item(FUNC_NEXT, 16'hFFFF);
    send_item(FUNC_NEXT, 16'h0000);
    send_item(FUNC_INSERT, 16'd7);
    send_item(FUNC_NEXT, 16'h5555);
    send_item(FUNC_NEXT, 16'hAAAA);
    send_item(FUNC_NEXT, 16'h0000);
    send_item(FUNC_NEXT, 16'h0000);
    send_item(FUNC_REWIND, 16'hFFFF);
    send_item(FUNC_NEXT, 16'h0000);
    send_item(FUNC_NEXT, 16'h0000);
    send_item(FUNC_INSERT, 16'hAAAA);
    send_item(FUNC_INSERT, 16'h5555);
    send_item(FUNC_UNUSED, 16'hFFFF);
    send_item(FUNC_NEXT, 16'h0000);
    send_item(FUNC_NEXT, 16'h0000);
    drain_results();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      quiet = (items_sent >= 600 && items_sent < 900);
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(3) == 0) send_item(FUNC_REWIND, VALUE_BITS'($urandom));
        base = $urandom_range(VALUE_BITS'('1));
        span = ($urandom_range(3) == 0) ? 4095 : 127;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          if (i == 0 || $urandom_range(7) != 0) v = VALUE_BITS'(base + $urandom_range(span));
          send_item(FUNC_INSERT, v);
        end
        m = $urandom_range(1, n + 2);
        for (int i = 0; i < m; i++) send_item(FUNC_NEXT, VALUE_BITS'($urandom));
      end else begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          case ($urandom_range(3))
            0:       v = '0;
            1:       v = '1;
            default: v = VALUE_BITS'($urandom);
          endcase
          send_item(FUNC_BITS'($urandom_range(3)), v);
        end
      end
      if ($urandom_range(29) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

@@ sim.f @@
design/bss_pkg.sv
design/bss_ram.sv
design/bss_lowbit.sv
design/bss_ctrl.sv
design/bitmap_set_sorter_top.sv
bench/bitmap_set_sorter_checker.sv
bench/tb_bitmap_set_sorter_top.sv
